>>> rtl/core/lens_dm_pkg.sv
// Shared constants and register codes for the lens distortion map core.
`default_nettype none
package lens_dm_pkg;

    // Field widths
    localparam int XY_W   = 22;
    localparam int OUT_W  = 24;
    localparam int ITER_W = 7;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // Default loop limits
    localparam int DEF_MAX_ITER   = 16;
    localparam int DEF_CONV_COUNT = 2;
    localparam int DEF_TOL_LSB    = 1;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] CFG_K1       = 3'd2;
    localparam logic [IDX_W-1:0] CFG_K2       = 3'd3;
    localparam logic [IDX_W-1:0] CFG_K3       = 3'd4;
    localparam logic [IDX_W-1:0] CFG_P1       = 3'd5;
    localparam logic [IDX_W-1:0] CFG_P2       = 3'd6;
    localparam logic [IDX_W-1:0] CFG_P3       = 3'd7;

    // Micro-program: each step is one product followed by one update
    localparam int          PC_W      = 5;
    localparam logic [4:0]  PC_FWD_END = 5'd19;
    localparam logic [4:0]  PC_END     = 5'd27;

    // Fixed-point constants
    localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;
    localparam logic signed [63:0] HALF_Q16 = 64'sd32768;
    localparam logic signed [64:0] ERR_LIM  = 65'sd140737488355328;
    localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;

    // Divider: quotient bits per Newton division
    localparam int DIV_N = 62;

endpackage
`default_nettype wire

>>> rtl/core/lens_distortion_map_core.sv
// Lens distortion map core: forward map and Newton inverse on one shared multiplier.
// Inverse item: up to MAX_ITER Newton steps, ending early once CONV_COUNT steps in a row are small.
// Each product is formed on the shared 32x32 multiplier from four partial products;
// each Newton division runs on a radix-2 divider, skipped on a zero derivative.
// Reset (synchronous, active low) clears the sequencer, output valid and config registers.
`default_nettype none
module lens_distortion_map_core #(
    parameter int MAX_ITER   = lens_dm_pkg::DEF_MAX_ITER,
    parameter int CONV_COUNT = lens_dm_pkg::DEF_CONV_COUNT,
    parameter int TOL_LSB    = lens_dm_pkg::DEF_TOL_LSB
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // x_in[21:0], y_in[43:22], zero pad
    input  wire  [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // x_out, y_out, iterations, converged, saturated
    input  wire         i_cfg_we,
    input  wire  [lens_dm_pkg::IDX_W-1:0] i_cfg_addr,
    input  wire  [lens_dm_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int RUN_W = $clog2(CONV_COUNT + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_MLD   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MNEG  = 4'd4;
    localparam logic [3:0] S_MSH   = 4'd5;
    localparam logic [3:0] S_ALU   = 4'd6;
    localparam logic [3:0] S_FWD   = 4'd7;
    localparam logic [3:0] S_DIVS  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_UPD   = 4'd10;
    localparam logic [3:0] S_WB    = 4'd11;

    // Configuration
    logic [21:0]        r_cx, r_cy;
    logic signed [31:0] r_k1, r_k2, r_k3, r_p1, r_p2, r_p3;

    // Sequencer and iterate
    logic [3:0]                     r_state;
    logic [lens_dm_pkg::PC_W-1:0]   r_pc;
    logic                           r_func;
    logic [21:0]                    r_xin, r_yin;
    logic signed [23:0]             r_xo, r_yo;
    logic [6:0]                     r_iter;
    logic [RUN_W-1:0]               r_run;
    logic                           r_clip, r_conv;

    // Evaluation registers
    logic signed [63:0] r_dx, r_dy, r_t1, r_r2, r_dxx, r_dyy, r_dxy, r_c3, r_c;
    logic signed [63:0] r_rad, r_inner, r_sc, r_pxy, r_tx, r_ty, r_gx, r_gy;
    logic signed [63:0] r_fx, r_fy, r_d, r_dfx, r_dfy, r_p;

    // Multiplier
    logic [63:0]  r_ma, r_mb;
    logic         r_mneg;
    logic [127:0] r_acc;
    logic [1:0]   r_mcnt;

    // Divider
    logic        r_axis;
    logic [63:0] r_rem, r_dm;
    logic [61:0] r_quo;
    logic        r_dneg;
    logic [5:0]  r_dcnt;
    logic [61:0] r_qxm, r_qym;
    logic        r_qxn, r_qyn;

    // Output register
    logic               r_ov;
    logic signed [23:0] r_xout, r_yout;
    logic [6:0]         r_iout;
    logic               r_cout, r_sout;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? lens_dm_pkg::S64_MIN : lens_dm_pkg::S64_MAX;
        end
        return s[63:0];
    endfunction

    // {clipped, value}
    function automatic logic [24:0] clip24(input logic signed [64:0] v);
        if (v > 65'sd8388607) begin
            return {1'b1, 24'h7FFFFF};
        end else if (v < -65'sd8388608) begin
            return {1'b1, 24'h800000};
        end
        return {1'b0, v[23:0]};
    endfunction

    // Operand selection for the shared multiplier
    logic signed [63:0] op_a, op_b;
    logic [6:0]         op_s;

    always_comb begin
        op_a = r_dx;
        op_b = r_dx;
        op_s = 7'd0;
        case (r_pc)
            5'd0:  begin op_a = r_dx;  op_b = r_dx;  op_s = 7'd0;  end
            5'd1:  begin op_a = r_dy;  op_b = r_dy;  op_s = 7'd0;  end
            5'd2:  begin op_a = r_dx;  op_b = r_dy;  op_s = 7'd0;  end
            5'd3:  begin op_a = 64'(r_k3); op_b = r_r2; op_s = 7'd32; end
            5'd4:  begin op_a = r_c;   op_b = r_r2;  op_s = 7'd48; end
            5'd5:  begin op_a = r_c;   op_b = r_r2;  op_s = 7'd54; end
            5'd6:  begin op_a = r_c3;  op_b = 64'sd3; op_s = 7'd0; end
            5'd7:  begin op_a = r_c;   op_b = r_r2;  op_s = 7'd48; end
            5'd8:  begin op_a = 64'(r_p3); op_b = r_r2; op_s = 7'd38; end
            5'd9:  begin op_a = 64'(r_p2); op_b = r_dxy; op_s = 7'd40; end
            5'd10: begin op_a = 64'(r_p1); op_b = r_r2 + r_dxx; op_s = 7'd40; end
            5'd11: begin op_a = 64'(r_p1); op_b = r_r2 + r_dyy; op_s = 7'd40; end
            5'd12: begin op_a = 64'(r_p1); op_b = r_dx; op_s = 7'd0; end
            5'd13: begin op_a = 64'(r_p2); op_b = r_dy; op_s = 7'd0; end
            5'd14: begin op_a = 64'(r_p1); op_b = r_dy; op_s = 7'd0; end
            5'd15: begin op_a = 64'(r_p2); op_b = r_dx; op_s = 7'd0; end
            5'd16: begin op_a = r_dx;  op_b = r_rad; op_s = 7'd14; end
            5'd17: begin op_a = r_tx;  op_b = r_sc;  op_s = 7'd30; end
            5'd18: begin op_a = r_dy;  op_b = r_rad; op_s = 7'd14; end
            5'd19: begin op_a = r_ty;  op_b = r_sc;  op_s = 7'd30; end
            5'd20: begin op_a = r_dxx; op_b = r_inner; op_s = 7'd54; end
            5'd21: begin op_a = r_gx;  op_b = r_sc;  op_s = 7'd56; end
            5'd22: begin op_a = r_tx;  op_b = 64'(r_p3); op_s = 7'd16; end
            5'd23: begin op_a = r_t1;  op_b = r_dx <<< 1; op_s = 7'd38; end
            5'd24: begin op_a = r_dyy; op_b = r_inner; op_s = 7'd54; end
            5'd25: begin op_a = r_gy;  op_b = r_sc;  op_s = 7'd56; end
            5'd26: begin op_a = r_ty;  op_b = 64'(r_p3); op_s = 7'd16; end
            5'd27: begin op_a = r_t1;  op_b = r_dy <<< 1; op_s = 7'd38; end
            default: begin op_a = r_dx; op_b = r_dx; op_s = 7'd0; end
        endcase
    end

    // Multiplier datapath
    logic [63:0]         pp;
    logic [127:0]        pp_sh;
    logic signed [127:0] prod_sh;

    always_comb begin
        pp = r_ma[32*r_mcnt[1] +: 32] * r_mb[32*r_mcnt[0] +: 32];
        case ({1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {pp, 64'd0};
            default: pp_sh = {64'd0, pp};
        endcase
        prod_sh = $signed(r_acc) >>> op_s;
    end

    // Divider datapath
    logic [21:0]        d_tgt;
    logic signed [63:0] d_f, d_der;
    logic signed [64:0] d_diff, d_err;
    logic [47:0]        d_emag;
    logic [63:0]        d_dmag;
    logic [64:0]        d_rsh;
    logic               d_ge;

    always_comb begin
        d_tgt  = r_axis ? r_yin : r_xin;
        d_f    = r_axis ? r_fy : r_fx;
        d_der  = r_axis ? r_dfy : r_dfx;
        d_diff = $signed({27'd0, d_tgt, 16'd0}) - {d_f[63], d_f};
        if (d_diff > lens_dm_pkg::ERR_LIM) begin
            d_err = lens_dm_pkg::ERR_LIM;
        end else if (d_diff < -lens_dm_pkg::ERR_LIM) begin
            d_err = -lens_dm_pkg::ERR_LIM;
        end else begin
            d_err = d_diff;
        end
        d_emag = d_err[64] ? 48'(-d_err) : 48'(d_err);
        d_dmag = d_der[63] ? 64'(-d_der) : 64'(d_der);
        d_rsh  = {r_rem, r_quo[61]};
        d_ge   = d_rsh >= {1'b0, r_dm};
    end

    // Iterate update
    logic signed [63:0] n_ddx, n_ddy;
    logic [24:0]        n_xc, n_yc, n_fxc, n_fyc;
    logic               n_small;
    logic [RUN_W-1:0]   n_run;
    logic [6:0]         n_iter;

    always_comb begin
        n_ddx   = r_qxn ? -$signed({2'b00, r_qxm}) : $signed({2'b00, r_qxm});
        n_ddy   = r_qyn ? -$signed({2'b00, r_qym}) : $signed({2'b00, r_qym});
        n_xc    = clip24({{41{r_xo[23]}}, r_xo} + {n_ddx[63], n_ddx});
        n_yc    = clip24({{41{r_yo[23]}}, r_yo} + {n_ddy[63], n_ddy});
        n_small = (r_qxm < 62'(TOL_LSB)) && (r_qym < 62'(TOL_LSB));
        n_run   = n_small ? r_run + 1'b1 : '0;
        n_iter  = r_iter + 7'd1;
        n_fxc   = clip24(65'(sadd(r_fx, lens_dm_pkg::HALF_Q16) >>> 16));
        n_fyc   = clip24(65'(sadd(r_fy, lens_dm_pkg::HALF_Q16) >>> 16));
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lens_dm_pkg::CFG_CENTER_X: r_cx <= i_cfg_data[21:0];
                lens_dm_pkg::CFG_CENTER_Y: r_cy <= i_cfg_data[21:0];
                lens_dm_pkg::CFG_K1:       r_k1 <= i_cfg_data;
                lens_dm_pkg::CFG_K2:       r_k2 <= i_cfg_data;
                lens_dm_pkg::CFG_K3:       r_k3 <= i_cfg_data;
                lens_dm_pkg::CFG_P1:       r_p1 <= i_cfg_data;
                lens_dm_pkg::CFG_P2:       r_p2 <= i_cfg_data;
                lens_dm_pkg::CFG_P3:       r_p3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // load a new result when the output register is free or draining
            if (r_state == S_WB && (!r_ov || m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: r_state <= S_MLD;
                S_MLD:   r_state <= S_MUL;
                S_MUL: begin
                    if (r_mcnt == 2'd3) begin
                        r_state <= S_MNEG;
                    end
                end
                S_MNEG: r_state <= S_MSH;
                S_MSH:  r_state <= S_ALU;
                S_ALU: begin
                    if (r_pc == lens_dm_pkg::PC_FWD_END && !r_func) begin
                        r_state <= S_FWD;
                    end else if (r_pc == lens_dm_pkg::PC_END) begin
                        r_state <= S_DIVS;
                    end else begin
                        r_state <= S_MLD;
                    end
                end
                S_FWD: r_state <= S_WB;
                S_DIVS: begin
                    if (d_der == 64'sd0) begin
                        r_state <= r_axis ? S_UPD : S_DIVS;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 6'(lens_dm_pkg::DIV_N - 1)) begin
                        r_state <= r_axis ? S_UPD : S_DIVS;
                    end
                end
                S_UPD: begin
                    if (n_run >= RUN_W'(CONV_COUNT) || n_iter == 7'(MAX_ITER)) begin
                        r_state <= S_WB;
                    end else begin
                        r_state <= S_SETUP;
                    end
                end
                S_WB: begin
                    if (!r_ov || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    r_func <= s_axis_tuser[0];
                    r_xin  <= s_axis_tdata[21:0];
                    r_yin  <= s_axis_tdata[43:22];
                    r_xo   <= {2'b00, s_axis_tdata[21:0]};
                    r_yo   <= {2'b00, s_axis_tdata[43:22]};
                    r_iter <= '0;
                    r_run  <= '0;
                    r_clip <= 1'b0;
                    r_conv <= 1'b0;
                end
            end
            S_SETUP: begin
                r_pc   <= '0;
                r_axis <= 1'b0;
                r_dx   <= {{40{r_xo[23]}}, r_xo} - {42'd0, r_cx};
                r_dy   <= {{40{r_yo[23]}}, r_yo} - {42'd0, r_cy};
            end
            S_MLD: begin
                r_ma   <= op_a[63] ? 64'(-op_a) : 64'(op_a);
                r_mb   <= op_b[63] ? 64'(-op_b) : 64'(op_b);
                r_mneg <= op_a[63] ^ op_b[63];
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            S_MUL: begin
                r_acc  <= r_acc + pp_sh;
                r_mcnt <= r_mcnt + 2'd1;
            end
            S_MNEG: begin
                if (r_mneg) begin
                    r_acc <= -r_acc;
                end
            end
            S_MSH: begin
                // keep the product only if it fits in 64 bits, else clamp
                if (prod_sh[127:63] == '0 || prod_sh[127:63] == '1) begin
                    r_p <= prod_sh[63:0];
                end else begin
                    r_p <= r_acc[127] ? lens_dm_pkg::S64_MIN : lens_dm_pkg::S64_MAX;
                end
            end
            S_ALU: begin
                r_pc <= r_pc + 1'b1;
                case (r_pc)
                    5'd0:  r_t1 <= r_p;
                    5'd1: begin
                        r_r2  <= r_t1 + r_p;
                        r_dxx <= r_t1 <<< 1;
                        r_dyy <= r_p <<< 1;
                    end
                    5'd2:  r_dxy <= r_p <<< 1;
                    5'd3: begin
                        r_c3 <= r_p;
                        r_c  <= sadd(64'(r_k2) <<< 16, r_p);
                    end
                    5'd4:  r_c     <= sadd(64'(r_k1) <<< 16, r_p);
                    5'd5:  r_rad   <= sadd(lens_dm_pkg::ONE_Q30, r_p);
                    5'd6:  r_c     <= sadd(64'(r_k2) <<< 17, r_p);
                    5'd7:  r_inner <= sadd(64'(r_k1) <<< 16, r_p);
                    5'd8:  r_sc    <= sadd(lens_dm_pkg::ONE_Q30, r_p);
                    5'd9:  r_pxy   <= r_p;
                    5'd10: r_tx    <= sadd(r_p, r_pxy);
                    5'd11: r_ty    <= sadd(r_p, r_pxy);
                    5'd12: r_t1    <= r_p;
                    5'd13: r_gx    <= (r_t1 <<< 2) + (r_t1 <<< 1) + (r_p <<< 1);
                    5'd14: r_t1    <= r_p;
                    5'd15: r_gy    <= (r_t1 <<< 2) + (r_t1 <<< 1) + (r_p <<< 1);
                    5'd16: r_fx    <= sadd({26'd0, r_cx, 16'd0}, r_p);
                    5'd17: r_fx    <= sadd(r_fx, r_p);
                    5'd18: r_fy    <= sadd({26'd0, r_cy, 16'd0}, r_p);
                    5'd19: r_fy    <= sadd(r_fy, r_p);
                    5'd20: r_d     <= sadd(r_rad, r_p);
                    5'd21: r_d     <= sadd(r_d, r_p);
                    5'd22: r_t1    <= r_p;
                    5'd23: r_dfx   <= sadd(r_d, r_p);
                    5'd24: r_d     <= sadd(r_rad, r_p);
                    5'd25: r_d     <= sadd(r_d, r_p);
                    5'd26: r_t1    <= r_p;
                    5'd27: r_dfy   <= sadd(r_d, r_p);
                    default: ;
                endcase
            end
            S_FWD: begin
                r_xo   <= n_fxc[23:0];
                r_yo   <= n_fyc[23:0];
                r_clip <= n_fxc[24] | n_fyc[24];
                r_iter <= 7'd1;
                r_conv <= 1'b1;
            end
            S_DIVS: begin
                r_quo  <= {d_emag, 14'd0};
                r_rem  <= '0;
                r_dm   <= d_dmag;
                r_dneg <= d_err[64] ^ d_der[63];
                r_dcnt <= '0;
                // zero derivative: skip the step on this axis
                if (d_der == 64'sd0) begin
                    r_axis <= 1'b1;
                    if (r_axis) begin
                        r_qym <= '0;
                        r_qyn <= 1'b0;
                    end else begin
                        r_qxm <= '0;
                        r_qxn <= 1'b0;
                    end
                end
            end
            S_DIV: begin
                r_rem  <= d_ge ? 64'(d_rsh - {1'b0, r_dm}) : d_rsh[63:0];
                r_quo  <= {r_quo[60:0], d_ge};
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'(lens_dm_pkg::DIV_N - 1)) begin
                    r_axis <= 1'b1;
                    if (r_axis) begin
                        r_qym <= {r_quo[60:0], d_ge};
                        r_qyn <= r_dneg;
                    end else begin
                        r_qxm <= {r_quo[60:0], d_ge};
                        r_qxn <= r_dneg;
                    end
                end
            end
            S_UPD: begin
                r_xo   <= n_xc[23:0];
                r_yo   <= n_yc[23:0];
                r_clip <= n_xc[24] | n_yc[24];
                r_run  <= n_run;
                r_iter <= n_iter;
                r_conv <= n_run >= RUN_W'(CONV_COUNT);
            end
            S_WB: begin
                if (!r_ov || m_axis_tready) begin
                    r_xout <= r_xo;
                    r_yout <= r_yo;
                    r_iout <= r_iter;
                    r_cout <= r_conv;
                    r_sout <= r_clip;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_sout, r_cout, r_iout, r_yout, r_xout};

    a_iter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[54:48] != 7'd0)
        else $error("result with zero iterations");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[54:48] <= 7'(MAX_ITER))
        else $error("iteration count beyond limit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while item in progress");

    a_fwd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[55]) |-> m_axis_tdata[54:48] == 7'(MAX_ITER))
        else $error("unconverged result before iteration limit");

endmodule
`default_nettype wire
